### hdl/jpt_pkg.sv
// ----------------------------------------------------------------------------
// jpt_pkg: shared types and constants of the joint torque unit
// Widths of the shift-add multipliers, controller states, register indexes,
// register reset values and the per-joint store write word.
// ----------------------------------------------------------------------------
package jpt_pkg;

	localparam int MCAND_W  = 48;
	localparam int MPLIER_W = 16;
	localparam int PROD_W   = 64;
	localparam int CNT_W    = 5;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_A,
		ST_MUL_B,
		ST_SUM,
		ST_DONE
	} jpt_state_t;

	localparam logic [2:0] REG_PROP_GAIN     = 3'd0;
	localparam logic [2:0] REG_RATE_GAIN     = 3'd1;
	localparam logic [2:0] REG_INTEGRAL_GAIN = 3'd2;
	localparam logic [2:0] REG_TORQUE_LIMIT  = 3'd3;
	localparam logic [2:0] REG_INV_TIMESTEP  = 3'd4;
	localparam logic [2:0] REG_WHEEL_MASK    = 3'd5;

	localparam logic [15:0] PROP_GAIN_RST     = 16'd12800;
	localparam logic [15:0] RATE_GAIN_RST     = 16'd256;
	localparam logic [15:0] INTEGRAL_GAIN_RST = 16'd0;
	localparam logic [30:0] TORQUE_LIMIT_RST  = 31'd98304;
	localparam logic [15:0] INV_TIMESTEP_RST  = 16'd1000;
	localparam logic [5:0]  WHEEL_MASK_RST    = 6'd36;

	typedef struct packed {
		logic        prev_we;
		logic        sum_we;
		logic [31:0] prev;
		logic [47:0] sum;
	} jpt_store_wr_t;

endpackage

### hdl/joint_pid_torque_with_wheel_clamp_unit.sv
// ----------------------------------------------------------------------------
// joint_pid_torque_with_wheel_clamp_unit: per-joint torque stage
// Wheel joints clamp the reference torque to +/- limit; leg joints form a
// PID torque from angle error, angle rate and error sum, saturated to 32 bits.
//
// Channel   Dir  Handshake                 Payload
// s_*       in   s_tvalid / s_tready       tdata: target, measured; tuser: joint
// m_*       out  m_tvalid / m_tready       tdata: torque; tuser: joint, clamped
// APB       in   psel, penable, pwrite     paddr 4*index, 32-bit data
//
// Leg joint: ST_MUL_A, ST_MUL_B, ST_SUM and ST_DONE, then the output register,
// paced by two rounds of 16-step shift-add multipliers (rate and gains first,
// then rate gain). Wheel joint: ST_DONE, then the output register. A new word
// is taken only in ST_IDLE. Joint out of range: dropped at once.
// Reset clears per-joint state and loads register defaults.
// A result held at the output stalls only the final load in ST_DONE; new words
// are taken while it waits, until the next result is ready to load.
// ----------------------------------------------------------------------------
module joint_pid_torque_with_wheel_clamp_unit #(
	parameter int JOINT_COUNT = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [31:0] target_angle, [63:32] measured_angle
	input  logic [2:0]  s_tuser,   // [2:0] joint_sel
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] torque
	output logic [3:0]  m_tuser    // [2:0] joint_out, [3] clamped
);
	import jpt_pkg::*;

	localparam int         IDX_W       = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;
	localparam logic [4:0] JOINT_LIMIT = 5'(JOINT_COUNT);

	logic [15:0] prop_gain_q;
	logic [15:0] rate_gain_q;
	logic [15:0] integral_gain_q;
	logic [30:0] torque_limit_q;
	logic [15:0] inv_timestep_q;
	logic [5:0]  wheel_mask_q;

	jpt_state_t state_q, state_d;

	logic        cfg_wr;
	logic        accept;
	logic        in_range;
	logic        wheel;
	logic [3:0]  joint_ext;
	logic [7:0]  mask_ext;
	logic [IDX_W-1:0] idx;

	logic [31:0] target;
	logic [31:0] meas;
	logic [31:0] prev_rd;
	logic [47:0] sum_rd;
	logic [32:0] err;
	logic [32:0] diff;
	logic [48:0] sum_wide;
	logic [47:0] sum_new;
	logic [32:0] t33;
	logic [32:0] lim33;
	logic [32:0] nlim33;
	logic [31:0] wheel_torque;
	logic        wheel_clamped;

	jpt_store_wr_t store_wr;

	logic              start_a;
	logic              start0;
	logic [MCAND_W-1:0]  mcand0;
	logic [MPLIER_W-1:0] mplier0;
	logic [PROD_W-1:0] prod0, prod1, prod2;
	logic              busy0, busy1, busy2;
	logic [47:0]       rate_sat;

	logic [57:0] total;
	logic [31:0] total_sat;
	logic        total_clamped;

	logic [2:0]  res_joint_q;
	logic [31:0] res_torque_q;
	logic        res_clamped_q;

	logic        out_free;
	logic        m_tvalid_q;
	logic [31:0] m_tdata_q;
	logic [3:0]  m_tuser_q;

	// configuration
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q     <= PROP_GAIN_RST;
			rate_gain_q     <= RATE_GAIN_RST;
			integral_gain_q <= INTEGRAL_GAIN_RST;
			torque_limit_q  <= TORQUE_LIMIT_RST;
			inv_timestep_q  <= INV_TIMESTEP_RST;
			wheel_mask_q    <= WHEEL_MASK_RST;
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				REG_PROP_GAIN:     prop_gain_q     <= pwdata[15:0];
				REG_RATE_GAIN:     rate_gain_q     <= pwdata[15:0];
				REG_INTEGRAL_GAIN: integral_gain_q <= pwdata[15:0];
				REG_TORQUE_LIMIT:  torque_limit_q  <= pwdata[30:0];
				REG_INV_TIMESTEP:  inv_timestep_q  <= pwdata[15:0];
				REG_WHEEL_MASK:    wheel_mask_q    <= pwdata[5:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_PROP_GAIN:     prdata = {16'd0, prop_gain_q};
			REG_RATE_GAIN:     prdata = {16'd0, rate_gain_q};
			REG_INTEGRAL_GAIN: prdata = {16'd0, integral_gain_q};
			REG_TORQUE_LIMIT:  prdata = {1'b0, torque_limit_q};
			REG_INV_TIMESTEP:  prdata = {16'd0, inv_timestep_q};
			REG_WHEEL_MASK:    prdata = {26'd0, wheel_mask_q};
			default:           prdata = '0;
		endcase
	end

	// input decode
	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid & s_tready;
	assign joint_ext = {1'b0, s_tuser};
	assign idx       = joint_ext[IDX_W-1:0];
	assign in_range  = ({2'b00, s_tuser} < JOINT_LIMIT);
	assign mask_ext  = {2'b00, wheel_mask_q};
	assign wheel     = mask_ext[s_tuser];
	assign target    = s_tdata[31:0];
	assign meas      = s_tdata[63:32];

	jpt_joint_store #(
		.DEPTH (JOINT_COUNT),
		.IDX_W (IDX_W)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.idx     (idx),
		.wr      (store_wr),
		.rd_prev (prev_rd),
		.rd_sum  (sum_rd)
	);

	assign err      = {target[31], target} - {meas[31], meas};
	assign diff     = {meas[31], meas} - {prev_rd[31], prev_rd};
	assign sum_wide = {sum_rd[47], sum_rd} + {{16{err[32]}}, err};

	always_comb begin
		if (sum_wide[48] != sum_wide[47]) begin
			sum_new = sum_wide[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
		end else begin
			sum_new = sum_wide[47:0];
		end
	end

	assign store_wr.prev_we = accept & in_range;
	assign store_wr.sum_we  = accept & in_range & ~wheel;
	assign store_wr.prev    = meas;
	assign store_wr.sum     = sum_new;

	// wheel clamp
	assign t33    = {target[31], target};
	assign lim33  = {2'b00, torque_limit_q};
	assign nlim33 = -lim33;

	always_comb begin
		wheel_torque  = target;
		wheel_clamped = 1'b0;
		if ($signed(t33) > $signed(lim33)) begin
			wheel_torque  = lim33[31:0];
			wheel_clamped = 1'b1;
		end else if ($signed(t33) < $signed(nlim33)) begin
			wheel_torque  = nlim33[31:0];
			wheel_clamped = 1'b1;
		end
	end

	// multipliers: unit 0 does rate then rate gain, units 1 and 2 the other gains
	assign start_a  = accept & in_range & ~wheel;
	assign start0   = start_a | ((state_q == ST_MUL_A) & ~busy0);
	assign mcand0   = (state_q == ST_IDLE) ? {{15{diff[32]}}, diff} : rate_sat;
	assign mplier0  = (state_q == ST_IDLE) ? inv_timestep_q : rate_gain_q;

	always_comb begin
		if ((&prod0[63:47]) || ~(|prod0[63:47])) begin
			rate_sat = prod0[47:0];
		end else begin
			rate_sat = prod0[63] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
		end
	end

	jpt_serial_mul u_mul_rate (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start0),
		.mcand   (mcand0),
		.mplier  (mplier0),
		.product (prod0),
		.busy    (busy0)
	);

	jpt_serial_mul u_mul_prop (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start_a),
		.mcand   ({{15{err[32]}}, err}),
		.mplier  (prop_gain_q),
		.product (prod1),
		.busy    (busy1)
	);

	jpt_serial_mul u_mul_int (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start_a),
		.mcand   (sum_new),
		.mplier  (integral_gain_q),
		.product (prod2),
		.busy    (busy2)
	);

	// combine: floor shift by 8 of each product, then saturate
	assign total = {{2{prod1[63]}}, prod1[63:8]}
	             - {{2{prod0[63]}}, prod0[63:8]}
	             + {{2{prod2[63]}}, prod2[63:8]};

	always_comb begin
		if ((&total[57:31]) || ~(|total[57:31])) begin
			total_sat     = total[31:0];
			total_clamped = 1'b0;
		end else begin
			total_sat     = total[57] ? 32'h8000_0000 : 32'h7FFF_FFFF;
			total_clamped = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_joint_q   <= s_tuser;
			res_torque_q  <= wheel_torque;
			res_clamped_q <= wheel_clamped;
		end else if (state_q == ST_SUM) begin
			res_torque_q  <= total_sat;
			res_clamped_q <= total_clamped;
		end
	end

	// controller
	assign out_free = ~m_tvalid_q | m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && in_range) begin
					state_d = wheel ? ST_DONE : ST_MUL_A;
				end
			end
			ST_MUL_A: begin
				if (!busy0) begin
					state_d = ST_MUL_B;
				end
			end
			ST_MUL_B: begin
				if (!busy0) begin
					state_d = ST_SUM;
				end
			end
			ST_SUM: state_d = ST_DONE;
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if ((state_q == ST_DONE) && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && out_free) begin
			m_tdata_q <= res_torque_q;
			m_tuser_q <= {res_clamped_q, res_joint_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

`ifndef SYNTHESIS
	a_gain_units_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL_B) |-> (!busy1 && !busy2))
		else $error("gain multipliers still running in second round");

	a_leg_start: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_range && !wheel) |=> (state_q == ST_MUL_A && busy0 && busy1 && busy2))
		else $error("leg word did not start the multipliers");

	a_out_joint_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ({2'b00, m_tuser[2:0]} < JOINT_LIMIT))
		else $error("result for a joint out of range");

	a_done_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_free) |=> (m_tvalid && state_q == ST_IDLE))
		else $error("finished result not loaded into output register");
`endif

endmodule

### hdl/jpt_serial_mul.sv
// ----------------------------------------------------------------------------
// jpt_serial_mul: bit-serial shift-add multiplier
// Signed 48-bit multiplicand times unsigned 16-bit multiplier, one multiplier
// bit per cycle, exact 64-bit product once busy drops; product holds after.
// ----------------------------------------------------------------------------
module jpt_serial_mul (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [jpt_pkg::MCAND_W-1:0]   mcand,
	input  logic [jpt_pkg::MPLIER_W-1:0]  mplier,
	output logic [jpt_pkg::PROD_W-1:0]    product,
	output logic                          busy
);
	import jpt_pkg::*;

	logic [PROD_W-1:0]   acc_q;
	logic [PROD_W-1:0]   addend_q;
	logic [MPLIER_W-1:0] mplier_q;
	logic [CNT_W-1:0]    cnt_q;

	assign busy    = (cnt_q != '0);
	assign product = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(MPLIER_W);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q    <= '0;
			addend_q <= {{(PROD_W-MCAND_W){mcand[MCAND_W-1]}}, mcand};
			mplier_q <= mplier;
		end else if (busy) begin
			if (mplier_q[0]) begin
				acc_q <= acc_q + addend_q;
			end
			addend_q <= addend_q << 1;
			mplier_q <= mplier_q >> 1;
		end
	end

endmodule

### hdl/jpt_joint_store.sv
// ----------------------------------------------------------------------------
// jpt_joint_store: per-joint previous angle and error sum
// One entry per joint, cleared by reset, read and written at one index.
// ----------------------------------------------------------------------------
module jpt_joint_store #(
	parameter int DEPTH = 6,
	parameter int IDX_W = 3
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [IDX_W-1:0]      idx,
	input  jpt_pkg::jpt_store_wr_t wr,
	output logic [31:0]           rd_prev,
	output logic [47:0]           rd_sum
);
	import jpt_pkg::*;

	logic [31:0] prev_q [DEPTH];
	logic [47:0] sum_q  [DEPTH];

	assign rd_prev = prev_q[idx];
	assign rd_sum  = sum_q[idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DEPTH; k++) begin
				prev_q[k] <= '0;
				sum_q[k]  <= '0;
			end
		end else begin
			if (wr.prev_we) begin
				prev_q[idx] <= wr.prev;
			end
			if (wr.sum_we) begin
				sum_q[idx] <= wr.sum;
			end
		end
	end

endmodule
